// ===== hdl/rmts_pkg.sv =====
// Package: shared types and codes for the rate-monotonic task scheduler.
package rmts_pkg;

  localparam int unsigned ACT_W = 3;
  localparam int unsigned TW = 16;
  localparam int unsigned SW = 3;
  localparam int unsigned MW = 8;

  localparam logic [ACT_W-1:0] ACT_TICK = 3'd0;
  localparam logic [ACT_W-1:0] ACT_REG = 3'd1;
  localparam logic [ACT_W-1:0] ACT_WAIT = 3'd2;
  localparam logic [ACT_W-1:0] ACT_TERM = 3'd3;
  localparam logic [ACT_W-1:0] ACT_ABORT = 3'd4;
  localparam logic [ACT_W-1:0] ACT_START = 3'd5;

  localparam logic [1:0] STS_OK = 2'd0;
  localparam logic [1:0] STS_ZERO = 2'd1;
  localparam logic [1:0] STS_FULL = 2'd2;
  localparam logic [1:0] STS_IGN = 2'd3;

  typedef struct packed {
    logic [ACT_W-1:0] action;
    logic [TW-1:0] task_period;
    logic [TW-1:0] task_budget;
  } in_item_t;

  typedef struct packed {
    logic [SW-1:0] running_slot;
    logic running_idle;
    logic [1:0] status;
    logic [SW-1:0] new_slot;
    logic [MW-1:0] missed_mask;
  } out_item_t;

  // controller -> datapath commands
  typedef struct packed {
    logic load;     // latch input item
    logic decide;   // immediate actions / register slot search
    logic charge;   // charge running task and requeue
    logic rq_step;  // decrement one ready entry
    logic wq_step;  // process one waiting entry
    logic wq_done;  // commit waiting compaction
    logic elect;    // elect head
    logic ins_step; // insertion shift step
  } cmd_t;

  typedef struct packed {
    logic is_tick;
    logic is_start_el;
    logic ins_busy;
    logic rq_last;
    logic wq_last;
    logic rq_empty;
    logic wq_empty;
  } sts_t;

endpackage

// ===== hdl/rmts_dp.sv =====
// Datapath: slot tables, ready and waiting queues, tick and insertion units.
module rmts_dp #(
  parameter int unsigned TASK_SLOTS = 8,
  parameter int unsigned TIME_BITS = 16
) (
  input  logic clk,
  input  logic rst_n,
  input  rmts_pkg::in_item_t in_item,
  input  rmts_pkg::cmd_t cmd,
  output rmts_pkg::sts_t sts,
  output rmts_pkg::out_item_t out_item
);

  localparam int unsigned IW = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
  localparam int unsigned CW = $clog2(TASK_SLOTS + 1);
  localparam logic [2:0] S_EMPTY = 3'd0;
  localparam logic [2:0] S_READY = 3'd1;
  localparam logic [2:0] S_WAIT = 3'd2;
  localparam logic [2:0] S_RUN = 3'd3;
  localparam logic [2:0] S_TERM = 3'd4;
  localparam logic [2:0] S_ABORT = 3'd5;

  logic [TIME_BITS-1:0] per_r [TASK_SLOTS];
  logic [TIME_BITS-1:0] bud_r [TASK_SLOTS];
  logic [TIME_BITS-1:0] act_r [TASK_SLOTS];
  logic [TIME_BITS-1:0] bl_r [TASK_SLOTS];
  logic [2:0] st_r [TASK_SLOTS];
  logic [IW-1:0] rq_r [TASK_SLOTS];
  logic [IW-1:0] wq_r [TASK_SLOTS];
  logic [CW-1:0] rc_r, wc_r, idx_r, keep_r, ipos_r;
  logic [IW-1:0] cur_r, islot_r;
  logic idle_r, wreq_r, ins_r;
  rmts_pkg::in_item_t it_r;
  logic [1:0] status_r;
  logic [IW-1:0] nslot_r;
  logic [TASK_SLOTS-1:0] miss_r;

  logic [TIME_BITS-1:0] per_m, bud_m;
  logic [IW-1:0] free_i;
  logic free_ok;
  logic [IW-1:0] rs, ws;
  logic [TIME_BITS-1:0] rdec, wdec, bl_dec;

  assign per_m = TIME_BITS'(it_r.task_period);
  assign bud_m = TIME_BITS'(it_r.task_budget);
  assign rs = rq_r[idx_r[IW-1:0]];
  assign ws = wq_r[idx_r[IW-1:0]];
  assign rdec = act_r[rs] - 1'b1;
  assign wdec = act_r[ws] - 1'b1;
  assign bl_dec = (bl_r[cur_r] != '0) ? bl_r[cur_r] - 1'b1 : '0;

  always_comb begin
    free_ok = 1'b0;
    free_i = '0;
    for (int i = TASK_SLOTS - 1; i >= 0; i--) begin
      if (st_r[i] == S_EMPTY) begin
        free_ok = 1'b1;
        free_i = IW'(i);
      end
    end
  end

  // Insertion walks the queue from the tail, one entry per cycle, shifting
  // larger periods back until the slot's place is found.
  logic ins_move;
  assign ins_move = (ipos_r != '0) &&
                    (per_r[rq_r[IW'(ipos_r - 1'b1)]] > per_r[islot_r]);

  assign sts.is_tick = (it_r.action == rmts_pkg::ACT_TICK);
  assign sts.is_start_el = (it_r.action == rmts_pkg::ACT_START) && idle_r;
  assign sts.ins_busy = ins_r;
  assign sts.rq_last = (idx_r + 1'b1) >= rc_r;
  assign sts.wq_last = (idx_r + 1'b1) >= wc_r;
  assign sts.rq_empty = (rc_r == '0);
  assign sts.wq_empty = (wc_r == '0);

  task automatic start_ins(input logic [IW-1:0] s);
    islot_r <= s;
    ipos_r <= rc_r;
    ins_r <= (rc_r < CW'(TASK_SLOTS));
  endtask

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < TASK_SLOTS; i++) st_r[i] <= S_EMPTY;
      rc_r <= '0;
      wc_r <= '0;
      cur_r <= '0;
      idle_r <= 1'b1;
      wreq_r <= 1'b0;
      ins_r <= 1'b0;
      idx_r <= '0;
      keep_r <= '0;
      ipos_r <= '0;
    end else begin
      if (cmd.load) begin
        it_r <= in_item;
        status_r <= rmts_pkg::STS_OK;
        nslot_r <= '0;
        miss_r <= '0;
        idx_r <= '0;
        keep_r <= '0;
      end
      if (cmd.decide) begin
        case (it_r.action)
          rmts_pkg::ACT_TICK: ;
          rmts_pkg::ACT_REG: begin
            if (per_m == '0 || bud_m == '0) status_r <= rmts_pkg::STS_ZERO;
            else if (!free_ok) status_r <= rmts_pkg::STS_FULL;
            else begin
              per_r[free_i] <= per_m;
              bud_r[free_i] <= bud_m;
              act_r[free_i] <= per_m;
              bl_r[free_i] <= bud_m;
              st_r[free_i] <= S_READY;
              nslot_r <= free_i;
              start_ins(free_i);
            end
          end
          rmts_pkg::ACT_WAIT: begin
            if (idle_r) status_r <= rmts_pkg::STS_IGN;
            else wreq_r <= 1'b1;
          end
          rmts_pkg::ACT_TERM, rmts_pkg::ACT_ABORT: begin
            if (idle_r) status_r <= rmts_pkg::STS_IGN;
            else begin
              st_r[cur_r] <= (it_r.action == rmts_pkg::ACT_TERM) ? S_TERM : S_ABORT;
              idle_r <= 1'b1;
              cur_r <= '0;
              wreq_r <= 1'b0;
            end
          end
          rmts_pkg::ACT_START: begin
            if (!idle_r) status_r <= rmts_pkg::STS_IGN;
          end
          default: status_r <= rmts_pkg::STS_IGN;
        endcase
      end
      if (cmd.charge) begin
        if (!idle_r) begin
          bl_r[cur_r] <= bl_dec;
          if (wreq_r || bl_dec == '0) begin
            if (wc_r < CW'(TASK_SLOTS)) begin
              wq_r[wc_r[IW-1:0]] <= cur_r;
              wc_r <= wc_r + 1'b1;
              st_r[cur_r] <= S_WAIT;
            end
          end else begin
            start_ins(cur_r);
          end
        end
        wreq_r <= 1'b0;
      end
      if (cmd.ins_step) begin
        if (ins_move) begin
          rq_r[ipos_r[IW-1:0]] <= rq_r[IW'(ipos_r - 1'b1)];
          ipos_r <= ipos_r - 1'b1;
        end else begin
          rq_r[ipos_r[IW-1:0]] <= islot_r;
          rc_r <= rc_r + 1'b1;
          st_r[islot_r] <= S_READY;
          ins_r <= 1'b0;
        end
      end
      if (cmd.rq_step) begin
        if (rdec == '0) begin
          if (bl_r[rs] != '0) miss_r[rs] <= 1'b1;
          act_r[rs] <= per_r[rs];
        end else begin
          act_r[rs] <= rdec;
        end
        idx_r <= sts.rq_last ? '0 : idx_r + 1'b1;
      end
      if (cmd.wq_step) begin
        if (wdec == '0) begin
          act_r[ws] <= per_r[ws];
          bl_r[ws] <= bud_r[ws];
          start_ins(ws);
        end else begin
          act_r[ws] <= wdec;
          wq_r[keep_r[IW-1:0]] <= ws;
          keep_r <= keep_r + 1'b1;
        end
        idx_r <= idx_r + 1'b1;
      end
      if (cmd.wq_done) wc_r <= keep_r;
      if (cmd.elect) begin
        if (rc_r == '0) begin
          idle_r <= 1'b1;
          cur_r <= '0;
        end else begin
          cur_r <= rq_r[0];
          for (int i = 1; i < TASK_SLOTS; i++) rq_r[i-1] <= rq_r[i];
          rc_r <= rc_r - 1'b1;
          idle_r <= 1'b0;
          st_r[rq_r[0]] <= S_RUN;
        end
      end
    end
  end

  always_comb begin
    out_item = '0;
    out_item.running_slot = idle_r ? '0 : rmts_pkg::SW'(cur_r);
    out_item.running_idle = idle_r;
    out_item.status = status_r;
    out_item.new_slot = rmts_pkg::SW'(nslot_r);
    out_item.missed_mask = rmts_pkg::MW'(miss_r);
  end

endmodule

// ===== hdl/rmts_ctrl.sv =====
// Controller: sequences one action through the datapath.
module rmts_ctrl (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  input  rmts_pkg::sts_t sts,
  output rmts_pkg::cmd_t cmd,
  output logic busy,
  output logic done
);

  typedef enum logic [3:0] {
    ST_IDLE, ST_DECIDE, ST_CHARGE, ST_RQ, ST_WQ, ST_INS, ST_WQD, ST_ELECT, ST_OUT
  } state_t;

  state_t state_r, state_nxt;
  logic busy_r, done_r;

  always_comb begin
    cmd = '0;
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (start) begin
        cmd.load = 1'b1;
        state_nxt = ST_DECIDE;
      end
      ST_DECIDE: begin
        cmd.decide = 1'b1;
        state_nxt = sts.is_tick ? ST_CHARGE : ST_INS;
      end
      ST_CHARGE: begin
        cmd.charge = 1'b1;
        state_nxt = ST_RQ;
      end
      ST_RQ: begin
        if (sts.ins_busy) cmd.ins_step = 1'b1;
        else if (sts.rq_empty) state_nxt = ST_WQ;
        else begin
          cmd.rq_step = 1'b1;
          if (sts.rq_last) state_nxt = ST_WQ;
        end
      end
      ST_WQ: begin
        if (sts.ins_busy) cmd.ins_step = 1'b1;
        else if (sts.wq_empty) state_nxt = ST_WQD;
        else begin
          cmd.wq_step = 1'b1;
          if (sts.wq_last) state_nxt = ST_INS;
        end
      end
      ST_INS: begin
        if (sts.ins_busy) cmd.ins_step = 1'b1;
        else if (sts.is_tick) state_nxt = ST_WQD;
        else state_nxt = sts.is_start_el ? ST_ELECT : ST_OUT;
      end
      ST_WQD: begin
        cmd.wq_done = 1'b1;
        state_nxt = ST_ELECT;
      end
      ST_ELECT: begin
        cmd.elect = 1'b1;
        state_nxt = ST_OUT;
      end
      ST_OUT: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      busy_r <= (state_nxt != ST_IDLE);
      done_r <= (state_r == ST_OUT);
    end
  end

  assign busy = busy_r;
  assign done = done_r;

endmodule

// ===== hdl/rate_monotonic_task_scheduler_core.sv =====
// Top level: rate-monotonic task scheduler core.
// One action is taken when start is high and busy low; busy stays high until
// the action is done and its result is then shown for one cycle with
// out_valid (no back-pressure). A tick charges the running task, walks the
// ready queue and then the waiting queue one entry per cycle and elects the
// head of the ready queue; every queue insertion shifts one entry per cycle,
// and a pending insertion is finished before either walk goes on.
module rate_monotonic_task_scheduler_core #(
  parameter int unsigned TASK_SLOTS = 8,
  parameter int unsigned TIME_BITS = 16
) (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  output logic busy,
  input  rmts_pkg::in_item_t in_item,
  output logic out_valid,
  output rmts_pkg::out_item_t out_item
);

  rmts_pkg::cmd_t cmd;
  rmts_pkg::sts_t sts;
  rmts_pkg::out_item_t dp_out;
  logic done;

  rmts_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .sts(sts),
    .cmd(cmd), .busy(busy), .done(done)
  );

  rmts_dp #(.TASK_SLOTS(TASK_SLOTS), .TIME_BITS(TIME_BITS)) u_dp (
    .clk(clk), .rst_n(rst_n), .in_item(in_item), .cmd(cmd),
    .sts(sts), .out_item(dp_out)
  );

  assign out_valid = done;
  assign out_item = dp_out;

`ifndef SYNTHESIS
  a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy)) else $error("result without transfer");
  a_one_shot: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result repeated");
  a_idle_slot: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.running_idle |-> out_item.running_slot == '0)
    else $error("idle with slot");
`endif

endmodule
